FILE: rtl/autoscaled_waveform_plotter_top_assert.svh
// Assertion macros for the waveform plotter top level.
// Expects clk and rst_n in the scope of the including module.
`ifndef AUTOSCALED_WAVEFORM_PLOTTER_TOP_ASSERT_SVH
`define AUTOSCALED_WAVEFORM_PLOTTER_TOP_ASSERT_SVH

// same-cycle implication
`define AWP_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define AWP_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/awp_pkg.sv
// Shared widths and constants of the autoscaled waveform plotter.
// No dependencies.
package awp_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int MAG_W          = SAMPLE_W + 1;
    localparam int PERIOD_W       = 8;
    localparam int ROW_W          = 6;
    localparam int PAIR_W         = 6;
    localparam int SCALE_SHIFT    = 5;
    localparam int SCALE_W        = SAMPLE_W - SCALE_SHIFT;
    localparam int CNT_W          = $clog2(MAG_W);
    localparam int MAX_PAIRS      = 64;
    localparam int OUT_DATA_W     = 24;
    localparam int ROW_MID        = 32;
    localparam int CLAMP_POS      = 32;
    localparam int CLAMP_NEG      = 31;
    localparam int PERIOD_RESET   = 5;
    localparam int DEF_WIN_DEPTH  = 256;
    localparam int DEF_COLUMNS    = 128;

endpackage

FILE: rtl/autoscaled_waveform_plotter_top.sv
// A sample that ends no frame is only stored; a frame runs a peak sweep over the
// whole window (one memory read per cycle), then per column two reads, a sum, a
// 17-step bit-serial divide and a clamp, plus one output word per column pair,
// which waits while the output is stalled.
// Throughput: one word per cycle between frames. Reset (rst_n, async) clears
// control state; the window reads as zero until filled, tracked by a fill count.
`include "autoscaled_waveform_plotter_top_assert.svh"

module autoscaled_waveform_plotter_top #(
    parameter int WINDOW_DEPTH = awp_pkg::DEF_WIN_DEPTH,
    parameter int COLUMNS      = awp_pkg::DEF_COLUMNS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [awp_pkg::SAMPLE_W-1:0]    s_tdata,     // [15:0] sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [awp_pkg::OUT_DATA_W-1:0]  m_tdata,     // [5:0] pair_index,
                                                         // [11:6] row_first,
                                                         // [17:12] row_second
    output logic                            m_tlast,     // last_of_frame
    input  logic                            cfg_wr_en,
    input  logic [awp_pkg::PERIOD_W-1:0]    cfg_wr_data  // frame_period
);
    import awp_pkg::*;

    localparam int AW        = $clog2(WINDOW_DEPTH);
    localparam int NCOLS     = (COLUMNS > 2 * MAX_PAIRS) ? 2 * MAX_PAIRS : COLUMNS;
    localparam int CW        = $clog2(NCOLS);
    localparam int LAST_PAIR = (NCOLS - 1) / 2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PEAK, ST_PEAK_END, ST_SCALE, ST_RD_A, ST_RD_B,
        ST_SUM, ST_DIV, ST_ROW, ST_EMIT
    } state_t;

    logic [SAMPLE_W-1:0]   mem [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic                  rd_ok_reg;
    logic [AW-1:0]         rd_addr;

    state_t                state_reg;
    logic [AW-1:0]         head_reg;
    logic [AW:0]           fill_reg;
    logic [PERIOD_W-1:0]   since_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [AW-1:0]         sweep_reg;
    logic [AW-1:0]         ptr_reg;
    logic                  peak_live_reg;
    logic [SAMPLE_W-1:0]   peak_reg;
    logic [SCALE_W-1:0]    scale_reg;
    logic [SAMPLE_W-1:0]   a_reg;
    logic                  neg_reg;
    logic [MAG_W-1:0]      dvd_reg;
    logic [SCALE_W-1:0]    rem_reg;
    logic [CNT_W-1:0]      bit_reg;
    logic [CW-1:0]         col_reg;
    logic [ROW_W-1:0]      row_a_reg;
    logic [ROW_W-1:0]      row_b_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;

    logic                  accept;
    logic [PERIOD_W-1:0]   since_inc;
    logic [SAMPLE_W-1:0]   samp;
    logic [SAMPLE_W-1:0]   samp_mag;
    logic [SCALE_W-1:0]    scale_raw;
    logic [MAG_W-1:0]      sum;
    logic [MAG_W-1:0]      sum_mag;
    logic [SCALE_W:0]      trial;
    logic                  trial_ge;
    logic [SCALE_W-1:0]    rem_new;
    logic [SAMPLE_W-1:0]   q_half;
    logic [ROW_W-1:0]      row;
    logic                  col_last;
    logic                  out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign since_inc = since_reg + 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign col_last  = (col_reg == CW'(NCOLS - 1));

    assign rd_addr   = (state_reg == ST_PEAK) ? sweep_reg : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[head_reg] <= s_tdata;
        end
        rd_data_reg <= mem[rd_addr];
        rd_ok_reg   <= (fill_reg > {1'b0, rd_addr});
    end

    always_comb
    begin
        samp      = rd_ok_reg ? rd_data_reg : '0;
        samp_mag  = samp[SAMPLE_W-1] ? (~samp + 1'b1) : samp;
        scale_raw = SCALE_W'(peak_reg >> SCALE_SHIFT);
        sum       = {a_reg[SAMPLE_W-1], a_reg} + {samp[SAMPLE_W-1], samp};
        sum_mag   = sum[MAG_W-1] ? (~sum + 1'b1) : sum;
        trial     = {rem_reg, dvd_reg[MAG_W-1]};
        trial_ge  = (trial >= {1'b0, scale_reg});
        rem_new   = trial_ge ? SCALE_W'(trial - {1'b0, scale_reg}) : SCALE_W'(trial);
        q_half    = dvd_reg[MAG_W-1:1];
        if (neg_reg)
        begin
            row = (q_half > SAMPLE_W'(CLAMP_NEG)) ? ROW_W'(ROW_MID + CLAMP_NEG)
                                                  : ROW_W'(ROW_MID) + q_half[ROW_W-1:0];
        end
        else
        begin
            row = (q_half > SAMPLE_W'(CLAMP_POS)) ? ROW_W'(ROW_MID - CLAMP_POS)
                                                  : ROW_W'(ROW_MID) - q_half[ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            since_reg     <= '0;
            period_reg    <= PERIOD_W'(PERIOD_RESET);
            sweep_reg     <= '0;
            ptr_reg       <= '0;
            peak_live_reg <= 1'b0;
            peak_reg      <= '0;
            scale_reg     <= '0;
            a_reg         <= '0;
            neg_reg       <= 1'b0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            bit_reg       <= '0;
            col_reg       <= '0;
            row_a_reg     <= '0;
            row_b_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tlast_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            peak_live_reg <= (state_reg == ST_PEAK);
            if (peak_live_reg && (samp_mag > peak_reg))
            begin
                peak_reg <= samp_mag;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        head_reg <= (head_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                        if (fill_reg != (AW+1)'(WINDOW_DEPTH))
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        if (since_inc == period_reg)
                        begin
                            since_reg <= '0;
                            sweep_reg <= '0;
                            peak_reg  <= '0;
                            state_reg <= ST_PEAK;
                        end
                        else
                        begin
                            since_reg <= since_inc;
                        end
                    end
                end
                ST_PEAK:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == AW'(WINDOW_DEPTH - 1))
                    begin
                        state_reg <= ST_PEAK_END;
                    end
                end
                ST_PEAK_END:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    scale_reg <= (scale_raw == '0) ? SCALE_W'(1) : scale_raw;
                    ptr_reg   <= head_reg;
                    col_reg   <= '0;
                    state_reg <= ST_RD_A;
                end
                ST_RD_A:
                begin
                    ptr_reg   <= (ptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                    state_reg <= ST_RD_B;
                end
                ST_RD_B:
                begin
                    a_reg     <= samp;
                    ptr_reg   <= (ptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    neg_reg   <= sum[MAG_W-1];
                    dvd_reg   <= sum_mag;
                    rem_reg   <= '0;
                    bit_reg   <= CNT_W'(MAG_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg <= rem_new;
                    dvd_reg <= {dvd_reg[MAG_W-2:0], trial_ge};
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0)
                    begin
                        state_reg <= ST_ROW;
                    end
                end
                ST_ROW:
                begin
                    if (!col_reg[0])
                    begin
                        row_a_reg <= row;
                        if (col_last)
                        begin
                            row_b_reg <= '0;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            col_reg   <= col_reg + 1'b1;
                            state_reg <= ST_RD_A;
                        end
                    end
                    else
                    begin
                        row_b_reg <= row;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= col_last;
                        m_tdata_reg  <= OUT_DATA_W'({row_b_reg, row_a_reg,
                                                     PAIR_W'(col_reg >> 1)});
                        if (col_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            col_reg   <= col_reg + 1'b1;
                            state_reg <= ST_RD_A;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `AWP_ASSERT_NOW(a_last_pair, m_tvalid && m_tlast, m_tdata[PAIR_W-1:0] == PAIR_W'(LAST_PAIR), "last word of frame carries wrong pair index")
    `AWP_ASSERT_NOW(a_rem_below, state_reg == ST_DIV, rem_reg < scale_reg, "divider remainder not below scale")
    `AWP_ASSERT_NOW(a_scale_set, state_reg == ST_SUM, scale_reg != '0, "zero scale at divide")
    `AWP_ASSERT_NEXT(a_fill_cap, accept, fill_reg <= (AW+1)'(WINDOW_DEPTH), "fill count past window depth")

endmodule

FILE: verif/tb_autoscaled_waveform_plotter_top.sv
// Self-checking testbench for autoscaled_waveform_plotter_top: streams samples,
// redraws each frame in a local predictor and checks every column pair word.
// Depends on awp_pkg and the plotter RTL.
module tb_autoscaled_waveform_plotter_top;

    import awp_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int PHASES      = 6;

    typedef struct packed {
        logic [PAIR_W-1:0] pair_index;
        logic [ROW_W-1:0]  row_first;
        logic [ROW_W-1:0]  row_second;
        logic              last_of_frame;
    } plot_pair_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en;
    logic [PERIOD_W-1:0]   cfg_wr_data;

    logic [SAMPLE_W-1:0] sample_queue[$];
    plot_pair_t          expected_pairs[$];

    logic [SAMPLE_W-1:0] window_mem [DEF_WIN_DEPTH];
    logic [7:0]          window_head;
    logic [7:0]          since_frame;
    logic [PERIOD_W-1:0] period_model;

    int   error_count;
    int   idle_cycles;
    int   send_gap;
    int   ready_gap;
    bit   word_taken;
    bit   progress;
    bit   next_valid;
    bit   steady;
    int   phase_period [PHASES] = '{1, 9, 7, 3, 0, 2};
    int   phase_items  [PHASES] = '{10, 40, 25, 30, 15, 15};
    bit   phase_steady [PHASES] = '{0, 0, 0, 1, 0, 0};
    logic [SAMPLE_W-1:0] directed [25] = '{
        16'sd1, -16'sd1, 16'sd2, 16'sd0, 16'sd3,
        16'sd40, 16'sd40, -16'sd40, -16'sd40, 16'sd5,
        16'sd32767, 16'sd32767, 16'h8000, 16'h8000, 16'sd0,
        16'h5555, 16'haaaa, -16'sd32767, 16'sd100, -16'sd100,
        16'sd31, 16'sd32, 16'sd33, -16'sd1, 16'sd1
    };

    autoscaled_waveform_plotter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int mode;
        int pick;
        mode = $urandom_range(0, 9);
        pick = $urandom_range(0, 3);
        if (mode < 4)
            return SAMPLE_W'($urandom);
        else if (mode < 7)
            return SAMPLE_W'($urandom_range(0, 80) - 40);
        else if (mode < 9)
            return SAMPLE_W'($urandom_range(0, 4000) - 2000);
        else if (pick == 0)
            return 16'h7fff;
        else if (pick == 1)
            return 16'h8000;
        else if (pick == 2)
            return 16'h8001;
        else
            return '0;
    endfunction

    function automatic logic [ROW_W-1:0] column_row(input int col, input int scale);
        int a;
        int b;
        int v;
        a = int'($signed(window_mem[(int'(window_head) + 2 * col) % DEF_WIN_DEPTH]));
        b = int'($signed(window_mem[(int'(window_head) + 2 * col + 1) % DEF_WIN_DEPTH]));
        v = ((a + b) / scale) / 2;
        if (v < -CLAMP_NEG)
            v = -CLAMP_NEG;
        if (v > CLAMP_POS)
            v = CLAMP_POS;
        return ROW_W'(ROW_MID - v);
    endfunction

    // store the sample, then draw a frame if the period is reached
    task automatic plot_sample(input logic [SAMPLE_W-1:0] sample);
        int peak;
        int mag;
        int scale;
        plot_pair_t pair;
        window_mem[window_head] = sample;
        window_head = window_head + 8'd1;
        since_frame = since_frame + 8'd1;
        if (since_frame == period_model)
        begin
            since_frame = '0;
            peak = 0;
            for (int i = 0; i < DEF_WIN_DEPTH; i++)
            begin
                mag = int'($signed(window_mem[i]));
                if (mag < 0)
                    mag = -mag;
                if (mag > peak)
                    peak = mag;
            end
            scale = peak >> SCALE_SHIFT;
            if (scale < 1)
                scale = 1;
            for (int k = 0; k < MAX_PAIRS; k++)
            begin
                pair.pair_index    = PAIR_W'(k);
                pair.row_first     = column_row(2 * k, scale);
                pair.row_second    = (2 * k + 1 < DEF_COLUMNS) ? column_row(2 * k + 1, scale)
                                                               : '0;
                pair.last_of_frame = (k == MAX_PAIRS - 1);
                expected_pairs.push_back(pair);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (sample_queue.size() != 0 || s_tvalid || expected_pairs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_period(input logic [PERIOD_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        period_model = value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // monitor: predicts on accepted samples, checks accepted result words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            progress = 1'b0;
            if (s_tvalid && s_tready)
            begin
                plot_sample(s_tdata);
                word_taken = 1'b1;
                progress   = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                progress = 1'b1;
                if (expected_pairs.size() == 0)
                    report_mismatch("unexpected word, pair", int'(m_tdata[5:0]), -1);
                else
                begin
                    if (m_tdata[5:0] != expected_pairs[0].pair_index)
                        report_mismatch("pair_index", int'(m_tdata[5:0]),
                                        int'(expected_pairs[0].pair_index));
                    if (m_tdata[11:6] != expected_pairs[0].row_first)
                        report_mismatch("row_first", int'(m_tdata[11:6]),
                                        int'(expected_pairs[0].row_first));
                    if (m_tdata[17:12] != expected_pairs[0].row_second)
                        report_mismatch("row_second", int'(m_tdata[17:12]),
                                        int'(expected_pairs[0].row_second));
                    if (m_tlast !== expected_pairs[0].last_of_frame)
                        report_mismatch("last_of_frame", int'(m_tlast),
                                        int'(expected_pairs[0].last_of_frame));
                    void'(expected_pairs.pop_front());
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (word_taken || !s_tvalid))
        begin
            word_taken = 1'b0;
            next_valid = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (sample_queue.size() > 0)
            begin
                s_tdata   <= sample_queue.pop_front();
                next_valid = 1'b1;
                send_gap   = pick_gap();
            end
            s_tvalid <= next_valid;
        end
    end

    // result backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_gap > 0)
            begin
                ready_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                ready_gap = pick_gap();
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        error_count = 0;
        idle_cycles = 0;
        send_gap    = 0;
        ready_gap   = 0;
        word_taken  = 1'b0;
        steady      = 1'b0;
        window_head = '0;
        since_frame = '0;
        period_model = PERIOD_W'(PERIOD_RESET);
        for (int i = 0; i < DEF_WIN_DEPTH; i++)
            window_mem[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // small peak, both clamps, most negative sample, bit patterns
        foreach (directed[i])
            sample_queue.push_back(directed[i]);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            steady = phase_steady[p];
            if (phase_period[p] == 0)
                set_period(PERIOD_W'($urandom_range(2, 9)));
            else
                set_period(PERIOD_W'(phase_period[p]));
            for (int n = 0; n < phase_items[p]; n++)
                sample_queue.push_back(random_sample());
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/awp_pkg.sv
rtl/autoscaled_waveform_plotter_top.sv
verif/tb_autoscaled_waveform_plotter_top.sv
